### src/cbd_pkg.sv
// Shared types and constants for the bus cycle decoder.
// Used by cbd_front, cbd_queue, cbd_back and cpu_bus_cycle_decoder; no dependencies.
package cbd_pkg;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        KIND_RESET = 3'd0,
        KIND_FETCH = 3'd1,
        KIND_MRD   = 3'd2,
        KIND_MWR   = 3'd3,
        KIND_IORD  = 3'd4,
        KIND_IOWR  = 3'd5,
        KIND_INTA  = 3'd6
    } kind_t;

    // What a sample means if it is taken as the second T-state.
    typedef enum logic [2:0] {
        T2_IDLE  = 3'd0,
        T2_FETCH = 3'd1,
        T2_INTA  = 3'd2,
        T2_MRD   = 3'd3,
        T2_MWR   = 3'd4,
        T2_IORD  = 3'd5,
        T2_IOWR  = 3'd6
    } t2_class_t;

    typedef enum logic [19:0] {
        PH_SYNC    = 20'h00001,
        PH_IDLE    = 20'h00002,
        PH_START   = 20'h00004,
        PH_RESET   = 20'h00008,
        PH_M1_WAIT = 20'h00010,
        PH_M1_T3   = 20'h00020,
        PH_M1_T4   = 20'h00040,
        PH_MR_WAIT = 20'h00080,
        PH_MR_T3   = 20'h00100,
        PH_MW_WAIT = 20'h00200,
        PH_MW_T3   = 20'h00400,
        PH_IR_TW   = 20'h00800,
        PH_IR_T3   = 20'h01000,
        PH_IW_TW   = 20'h02000,
        PH_IW_T3   = 20'h04000,
        PH_IA_TW1  = 20'h08000,
        PH_IA_TW2  = 20'h10000,
        PH_IA_TW   = 20'h20000,
        PH_IA_T3   = 20'h40000,
        PH_IA_T4   = 20'h80000
    } phase_t;

    // One classified bus sample, active-high flags.
    typedef struct packed {
        logic [15:0] addr;
        logic [7:0]  data;
        t2_class_t   t2_class;
        logic        sync_hit;
        logic        req_any;
        logic        waitreq;
        logic        halt;
        logic        irq;
        logic        rst;
    } sample_t;

endpackage

### src/cbd_front.sv
// Front end: turns raw active-low bus pins into a classified sample.
// Depends on cbd_pkg.
module cbd_front
    import cbd_pkg::*;
(
    input  logic [15:0] address,
    input  logic [7:0]  data,
    input  logic        m1_n,
    input  logic        mreq_n,
    input  logic        iorq_n,
    input  logic        rd_n,
    input  logic        wr_n,
    input  logic        halt_n,
    input  logic        wait_n,
    input  logic        int_n,
    input  logic        reset_n,
    output sample_t     sample
);

    logic m1;
    logic mreq;
    logic iorq;
    logic rd;
    logic wr;

    assign m1   = ~m1_n;
    assign mreq = ~mreq_n;
    assign iorq = ~iorq_n;
    assign rd   = ~rd_n;
    assign wr   = ~wr_n;

    always_comb
    begin
        sample.addr     = address;
        sample.data     = data;
        sample.sync_hit = m1 & mreq;
        sample.req_any  = mreq | iorq;
        sample.waitreq  = ~wait_n;
        sample.halt     = ~halt_n;
        sample.irq      = ~int_n;
        sample.rst      = ~reset_n;
        // Memory request wins over I/O request, and read over write.
        priority if (m1)
        begin
            sample.t2_class = mreq ? T2_FETCH : T2_INTA;
        end
        else if (mreq)
        begin
            sample.t2_class = rd ? T2_MRD : (wr ? T2_MWR : T2_IDLE);
        end
        else if (iorq)
        begin
            sample.t2_class = rd ? T2_IORD : (wr ? T2_IOWR : T2_IDLE);
        end
        else
        begin
            sample.t2_class = T2_IDLE;
        end
    end

endmodule

### src/cbd_queue.sv
// Short first-in first-out queue of classified samples between front and back.
// Depends on cbd_pkg.
module cbd_queue
    import cbd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  sample_t push_data,
    input  logic    pop,
    output sample_t head,
    output logic    not_empty,
    output logic    full
);

    sample_t            entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_next;

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == QCNT_W'(QDEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### src/cbd_back.sv
// Back end: T-state tracker that consumes classified samples and emits cycle records.
// Depends on cbd_pkg; records leave through an output register.
module cbd_back
    import cbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sample_t     head,
    input  logic        head_valid,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  cycle_kind,
    output logic [15:0] cycle_address,
    output logic [7:0]  cycle_data,
    output logic [7:0]  waits,
    output logic        halted,
    output logic        irq_pending
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [15:0] held_address_reg;
    logic [15:0] held_address_next;
    logic [7:0]  held_data_reg;
    logic [7:0]  held_data_next;
    logic [7:0]  wait_tally_reg;
    logic [7:0]  wait_tally_next;
    logic        held_halt_reg;
    logic        held_halt_next;
    logic        held_irq_reg;
    logic        held_irq_next;
    logic        emit;
    kind_t       emit_kind;

    logic        out_valid_reg;
    kind_t       out_kind_reg;
    logic [15:0] out_address_reg;
    logic [7:0]  out_data_reg;
    logic [7:0]  out_waits_reg;
    logic        out_halt_reg;
    logic        out_irq_reg;

    logic [7:0]  tally_inc;

    // A sample is taken whenever the output register can absorb a possible record.
    assign pop       = head_valid && (!out_valid_reg || out_ready);
    assign tally_inc = wait_tally_reg + 8'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        held_address_next = held_address_reg;
        held_data_next    = held_data_reg;
        wait_tally_next   = wait_tally_reg;
        held_halt_next    = held_halt_reg;
        held_irq_next     = held_irq_reg;
        emit              = 1'b0;
        emit_kind         = KIND_RESET;

        // Second T-state decision, shared by the idle, start and sync edges.
        if ((phase_reg == PH_START)
            || (phase_reg == PH_IDLE && !head.rst && head.req_any)
            || (phase_reg == PH_SYNC && !head.rst && head.sync_hit))
        begin
            held_address_next = head.addr;
            held_halt_next    = head.halt;
            wait_tally_next   = '0;
            held_data_next    = ((head.t2_class == T2_MWR) || (head.t2_class == T2_IOWR))
                                ? head.data : 8'd0;
        end

        unique case (phase_reg)
            PH_SYNC:
            begin
                if (head.rst)
                begin
                    phase_next = PH_RESET;
                end
                else if (head.sync_hit)
                begin
                    phase_next = head.waitreq ? PH_M1_WAIT : PH_M1_T3;
                end
            end
            PH_IDLE, PH_START:
            begin
                if (phase_reg == PH_IDLE && head.rst)
                begin
                    phase_next = PH_RESET;
                end
                else if (phase_reg == PH_IDLE && !head.req_any)
                begin
                    phase_next = PH_START;
                end
                else
                begin
                    unique case (head.t2_class)
                        T2_FETCH: phase_next = head.waitreq ? PH_M1_WAIT : PH_M1_T3;
                        T2_INTA:  phase_next = PH_IA_TW1;
                        T2_MRD:   phase_next = head.waitreq ? PH_MR_WAIT : PH_MR_T3;
                        T2_MWR:   phase_next = head.waitreq ? PH_MW_WAIT : PH_MW_T3;
                        T2_IORD:  phase_next = PH_IR_TW;
                        T2_IOWR:  phase_next = PH_IW_TW;
                        default:  phase_next = PH_IDLE;
                    endcase
                end
            end
            PH_RESET:
            begin
                if (!head.rst)
                begin
                    held_address_next = '0;
                    held_data_next    = '0;
                    wait_tally_next   = '0;
                    held_halt_next    = 1'b0;
                    held_irq_next     = 1'b0;
                    phase_next        = PH_SYNC;
                    emit              = 1'b1;
                    emit_kind         = KIND_RESET;
                end
            end
            PH_M1_WAIT:
            begin
                wait_tally_next = tally_inc;
                if (!head.waitreq)
                begin
                    phase_next = PH_M1_T3;
                end
            end
            PH_M1_T3:
            begin
                held_data_next = head.data;
                phase_next     = PH_M1_T4;
            end
            PH_M1_T4:
            begin
                held_irq_next = head.irq;
                phase_next    = PH_IDLE;
                emit          = 1'b1;
                emit_kind     = KIND_FETCH;
            end
            PH_MR_WAIT:
            begin
                wait_tally_next = tally_inc;
                if (!head.waitreq)
                begin
                    phase_next = PH_MR_T3;
                end
            end
            PH_MR_T3:
            begin
                held_data_next = head.data;
                phase_next     = PH_IDLE;
                emit           = 1'b1;
                emit_kind      = KIND_MRD;
            end
            PH_MW_WAIT:
            begin
                wait_tally_next = tally_inc;
                if (!head.waitreq)
                begin
                    phase_next = PH_MW_T3;
                end
            end
            PH_MW_T3:
            begin
                phase_next = PH_IDLE;
                emit       = 1'b1;
                emit_kind  = KIND_MWR;
            end
            PH_IR_TW:
            begin
                wait_tally_next = tally_inc;
                if (!head.waitreq)
                begin
                    phase_next = PH_IR_T3;
                end
            end
            PH_IR_T3:
            begin
                held_data_next = head.data;
                phase_next     = PH_IDLE;
                emit           = 1'b1;
                emit_kind      = KIND_IORD;
            end
            PH_IW_TW:
            begin
                wait_tally_next = tally_inc;
                if (!head.waitreq)
                begin
                    phase_next = PH_IW_T3;
                end
            end
            PH_IW_T3:
            begin
                phase_next = PH_IDLE;
                emit       = 1'b1;
                emit_kind  = KIND_IOWR;
            end
            PH_IA_TW1:
            begin
                wait_tally_next = tally_inc;
                phase_next      = PH_IA_TW2;
            end
            PH_IA_TW2, PH_IA_TW:
            begin
                wait_tally_next = tally_inc;
                phase_next      = head.waitreq ? PH_IA_TW : PH_IA_T3;
            end
            PH_IA_T3:
            begin
                held_data_next = head.data;
                phase_next     = PH_IA_T4;
            end
            PH_IA_T4:
            begin
                held_irq_next = head.irq;
                phase_next    = PH_IDLE;
                emit          = 1'b1;
                emit_kind     = KIND_INTA;
            end
            default:
            begin
                phase_next = PH_SYNC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SYNC;
            held_address_reg <= '0;
            held_data_reg    <= '0;
            wait_tally_reg   <= '0;
            held_halt_reg    <= 1'b0;
            held_irq_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg        <= phase_next;
                held_address_reg <= held_address_next;
                held_data_reg    <= held_data_next;
                wait_tally_reg   <= wait_tally_next;
                held_halt_reg    <= held_halt_next;
                held_irq_reg     <= held_irq_next;
            end
            if (pop && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The record carries the held values as they stand after this sample.
    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            out_kind_reg    <= emit_kind;
            out_address_reg <= held_address_next;
            out_data_reg    <= held_data_next;
            out_waits_reg   <= wait_tally_next;
            out_halt_reg    <= held_halt_next;
            out_irq_reg     <= held_irq_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cycle_kind    = out_kind_reg;
    assign cycle_address = out_address_reg;
    assign cycle_data    = out_data_reg;
    assign waits         = out_waits_reg;
    assign halted        = out_halt_reg;
    assign irq_pending   = out_irq_reg;

    a_reset_release: assert property (@(posedge clk) disable iff (!rst_n)
        pop && phase_reg == PH_RESET && !head.rst
        |=> phase_reg == PH_SYNC && wait_tally_reg == 8'd0 && !held_irq_reg)
        else $error("reset release did not return to sync hunting with cleared state");

    a_reset_record: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == KIND_RESET
        |-> out_address_reg == 16'd0 && out_data_reg == 8'd0 && out_waits_reg == 8'd0)
        else $error("reset record carries nonzero fields");

    a_inta_auto_wait: assert property (@(posedge clk) disable iff (!rst_n)
        pop && phase_reg == PH_IA_TW1 |=> phase_reg == PH_IA_TW2 && wait_tally_reg == 8'd1)
        else $error("interrupt acknowledge skipped its automatic waits");

endmodule

### src/cpu_bus_cycle_decoder.sv
// A sample that completes a bus cycle yields its record through the queue stage and then
// the output register; the record waits longer if the output side stalls.
// Throughput: one bus sample per clock while out_ready keeps up, set by the tracker popping the queue.
// A 4-entry sample queue lets the input side run on while the record output is stalled.
// Reset: rst_n clears the queue, drops out_valid and puts the tracker in sync hunting
// with all held values zero.
module cpu_bus_cycle_decoder
    import cbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    input  logic        m1_n,
    input  logic        mreq_n,
    input  logic        iorq_n,
    input  logic        rd_n,
    input  logic        wr_n,
    input  logic        halt_n,
    input  logic        wait_n,
    input  logic        int_n,
    input  logic        reset_n,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  cycle_kind,
    output logic [15:0] cycle_address,
    output logic [7:0]  cycle_data,
    output logic [7:0]  waits,
    output logic        halted,
    output logic        irq_pending
);

    sample_t sample;
    sample_t head;
    logic    q_not_empty;
    logic    q_full;
    logic    q_pop;

    assign in_ready = ~q_full;

    cbd_front u_front (
        .address (address),
        .data    (data),
        .m1_n    (m1_n),
        .mreq_n  (mreq_n),
        .iorq_n  (iorq_n),
        .rd_n    (rd_n),
        .wr_n    (wr_n),
        .halt_n  (halt_n),
        .wait_n  (wait_n),
        .int_n   (int_n),
        .reset_n (reset_n),
        .sample  (sample)
    );

    cbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && in_ready),
        .push_data (sample),
        .pop       (q_pop),
        .head      (head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    cbd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_valid    (q_not_empty),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cycle_kind    (cycle_kind),
        .cycle_address (cycle_address),
        .cycle_data    (cycle_data),
        .waits         (waits),
        .halted        (halted),
        .irq_pending   (irq_pending)
    );

endmodule
